/* rtl/mhpq_pkg.sv */
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

	localparam int KEY_W    = 16;
	localparam int TAG_W    = 16;
	localparam int SUM_W    = 23;
	localparam int TOTAL_W  = 7;
	localparam int STATUS_W = 2;

	// One heap slot: key in the upper half, tag in the lower half
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	// Request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

/* rtl/mhpq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/max_heap_priority_queue.sv */
// Top level of the max-heap priority queue: sequencer around the heap RAM.
//
// Usage: a request is taken when start is high and busy is low. op selects
// insert (key, tag enter the heap) or delete-max (the root leaves the heap).
// Each request produces exactly one result, shown for one cycle with done
// high: out_key/out_tag (removed entry, zero otherwise), status, entry_total
// and key_sum after the request. The receiver cannot stall; done is a pulse.
// Sequencing:
//   refused request (full or empty): done in the cycle after acceptance.
//   insert: one level climbed per S_UP_CMP step; each step compares the
//     parent already read while writing the moved entry and reading the
//     next parent.
//   delete: root and last entry are read in turn, then each level down reads
//     the left and, if present, the right child on the single read port.
// busy stays high until done (a refused request never raises it), so the next
// request may come with done. Reset clears the entry count and key sum; the heap
// RAM is not cleared and no slot's data is used before that slot is written.
module max_heap_priority_queue #(
	parameter int CAPACITY = 127
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            op,
	input  logic [mhpq_pkg::KEY_W-1:0]      key,
	input  logic [mhpq_pkg::TAG_W-1:0]      tag,
	output logic                            busy,
	output logic                            done,
	output logic [mhpq_pkg::KEY_W-1:0]      out_key,
	output logic [mhpq_pkg::TAG_W-1:0]      out_tag,
	output logic [mhpq_pkg::STATUS_W-1:0]   status,
	output logic [mhpq_pkg::TOTAL_W-1:0]    entry_total,
	output logic [mhpq_pkg::SUM_W-1:0]      key_sum
);

	import mhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_UP_FIN,
		S_DEL_TOP,
		S_DEL_LAST,
		S_DN_L,
		S_DN_R,
		S_DN_FIN
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0]         pos_q, pos_d;     // insert position or delete hole
	logic [AW:0]           kid_q, kid_d;     // left child index during sift-down
	logic [AW-1:0]         count_q, count_d;
	logic [SUM_W-1:0]      sum_q, sum_d;
	logic [KEY_W-1:0]      key_q, key_d;
	logic [TAG_W-1:0]      tag_q, tag_d;
	entry_t                top_q, top_d;
	entry_t                last_q, last_d;
	entry_t                left_q, left_d;

	logic                  done_d;
	logic [KEY_W-1:0]      out_key_d;
	logic [TAG_W-1:0]      out_tag_d;
	logic [STATUS_W-1:0]   status_d;
	logic [TOTAL_W-1:0]    entry_total_d;
	logic [SUM_W-1:0]      key_sum_d;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	entry_t                mem_wdata;
	logic [AW-1:0]         mem_raddr;
	entry_t                rd_ent;

	logic [AW-1:0]         last_n;
	logic [AW-1:0]         par_idx;
	logic                  right_pick;
	entry_t                ch_ent;
	logic [AW-1:0]         ch_idx;
	logic [AW:0]           next_kid;
	logic                  eval;
	logic                  fin_ins;
	logic                  fin_del;
	logic                  fin_ref;
	logic [STATUS_W-1:0]   ref_stat;

	// Heap storage, slots 1..CAPACITY
	mhpq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY + 1)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_ent)
	);

	assign busy = (state_q != S_IDLE);

	// Index helpers
	assign last_n     = count_q - AW'(1);
	assign par_idx    = pos_q >> 1;
	assign right_pick = (state_q == S_DN_R) && (left_q.key < rd_ent.key);
	assign ch_ent     = (state_q == S_DN_R && !right_pick) ? left_q : rd_ent;
	assign ch_idx     = right_pick ? (kid_q[AW-1:0] + AW'(1)) : kid_q[AW-1:0];
	assign next_kid   = {ch_idx, 1'b0};

	// Sequencer next-state logic
	always_comb begin
		state_d       = state_q;
		pos_d         = pos_q;
		kid_d         = kid_q;
		count_d       = count_q;
		sum_d         = sum_q;
		key_d         = key_q;
		tag_d         = tag_q;
		top_d         = top_q;
		last_d        = last_q;
		left_d        = left_q;
		done_d        = 1'b0;
		out_key_d     = out_key;
		out_tag_d     = out_tag;
		status_d      = status;
		entry_total_d = entry_total;
		key_sum_d     = key_sum;
		mem_we        = 1'b0;
		mem_waddr     = pos_q;
		mem_wdata     = '{key: key_q, tag: tag_q};
		mem_raddr     = pos_q;
		eval          = 1'b0;
		fin_ins       = 1'b0;
		fin_del       = 1'b0;
		fin_ref       = 1'b0;
		ref_stat      = STAT_OK;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = key;
					tag_d = tag;
					if (op == OP_INSERT) begin
						if (count_q >= AW'(CAPACITY)) begin
							fin_ref  = 1'b1;
							ref_stat = STAT_FULL;
						end else begin
							pos_d = count_q + AW'(1);
							if (count_q == '0) begin
								state_d = S_UP_FIN;
							end else begin
								mem_raddr = (count_q + AW'(1)) >> 1;
								state_d   = S_UP_CMP;
							end
						end
					end else begin
						if (count_q == '0) begin
							fin_ref  = 1'b1;
							ref_stat = STAT_EMPTY;
						end else begin
							mem_raddr = AW'(1);
							state_d   = S_DEL_TOP;
						end
					end
				end
			end
			// Parent data is in rd_ent; move it down or place the new entry
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (key_q > rd_ent.key) begin
					mem_wdata = rd_ent;
					pos_d     = par_idx;
					if (par_idx == AW'(1)) begin
						state_d = S_UP_FIN;
					end else begin
						mem_raddr = par_idx >> 1;
					end
				end else begin
					fin_ins = 1'b1;
				end
			end
			S_UP_FIN: begin
				mem_we  = 1'b1;
				fin_ins = 1'b1;
			end
			S_DEL_TOP: begin
				top_d     = rd_ent;
				mem_raddr = count_q;
				state_d   = S_DEL_LAST;
			end
			S_DEL_LAST: begin
				last_d = rd_ent;
				pos_d  = AW'(1);
				if (last_n < AW'(2)) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(1);
					mem_wdata = rd_ent;
					fin_del   = 1'b1;
				end else begin
					mem_raddr = AW'(2);
					kid_d     = (AW + 1)'(2);
					state_d   = S_DN_L;
				end
			end
			S_DN_L: begin
				left_d = rd_ent;
				if (kid_q < {1'b0, last_n}) begin
					mem_raddr = kid_q[AW-1:0] + AW'(1);
					state_d   = S_DN_R;
				end else begin
					eval = 1'b1;
				end
			end
			S_DN_R: begin
				eval = 1'b1;
			end
			S_DN_FIN: begin
				mem_we    = 1'b1;
				mem_wdata = last_q;
				fin_del   = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// One sift-down level against the chosen child
		if (eval) begin
			mem_we = 1'b1;
			if (last_q.key >= ch_ent.key) begin
				mem_wdata = last_q;
				fin_del   = 1'b1;
			end else begin
				mem_wdata = ch_ent;
				pos_d     = ch_idx;
				kid_d     = next_kid;
				if (next_kid <= {1'b0, last_n}) begin
					mem_raddr = next_kid[AW-1:0];
					state_d   = S_DN_L;
				end else begin
					state_d = S_DN_FIN;
				end
			end
		end

		// Result formation
		if (fin_ins) begin
			count_d   = count_q + AW'(1);
			sum_d     = sum_q + SUM_W'(key_q);
			out_key_d = '0;
			out_tag_d = '0;
			status_d  = STAT_OK;
		end else if (fin_del) begin
			count_d   = last_n;
			sum_d     = sum_q - SUM_W'(top_q.key);
			out_key_d = top_q.key;
			out_tag_d = top_q.tag;
			status_d  = STAT_OK;
		end else if (fin_ref) begin
			out_key_d = '0;
			out_tag_d = '0;
			status_d  = ref_stat;
		end
		if (fin_ins || fin_del || fin_ref) begin
			state_d       = S_IDLE;
			done_d        = 1'b1;
			entry_total_d = TOTAL_W'(count_d);
			key_sum_d     = sum_d;
		end
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			kid_q       <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			key_q       <= '0;
			tag_q       <= '0;
			top_q       <= '0;
			last_q      <= '0;
			left_q      <= '0;
			done        <= 1'b0;
			out_key     <= '0;
			out_tag     <= '0;
			status      <= STAT_OK;
			entry_total <= '0;
			key_sum     <= '0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			kid_q       <= kid_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			key_q       <= key_d;
			tag_q       <= tag_d;
			top_q       <= top_d;
			last_q      <= last_d;
			left_q      <= left_d;
			done        <= done_d;
			out_key     <= out_key_d;
			out_tag     <= out_tag_d;
			status      <= status_d;
			entry_total <= entry_total_d;
			key_sum     <= key_sum_d;
		end
	end

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(CAPACITY))
		else $error("entry count above capacity");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither working nor finished");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("heap RAM written while idle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (out_key == '0 && out_tag == '0))
		else $error("refused delete returned an entry");

endmodule
